// ===== rtl/core/cwls_pkg.sv =====
// ----------------------------------------------------------------------------
// cwls_pkg
// Shared types and constants for the context window line selector.
// ----------------------------------------------------------------------------
package cwls_pkg;

   localparam int MaxContext = 16;
   localparam int CtxWidth   = 5;
   localparam int TagWidth   = 16;
   localparam int SkipWidth  = 24;
   localparam int FillWidth  = $clog2(MaxContext + 1);
   localparam int HeadWidth  = (MaxContext > 1) ? $clog2(MaxContext) : 1;
   localparam int CmpWidth   = (CtxWidth > FillWidth) ? CtxWidth : FillWidth;

   localparam logic [SkipWidth-1:0] SkipMax = {SkipWidth{1'b1}};

   localparam logic ModeEntry = 1'b0;
   localparam logic ModeDrain = 1'b1;

   localparam logic KindEntry = 1'b0;
   localparam logic KindSep   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SEP,
      ST_ENT,
      ST_DRAIN,
      ST_FIN
   } seq_state_type;

   typedef struct packed {
      logic                 kind;
      logic [TagWidth-1:0]  tag;
      logic                 marked;
      logic [SkipWidth-1:0] skipped;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic                 en;
      logic [HeadWidth-1:0] addr;
      logic [TagWidth-1:0]  tag;
      logic                 mark;
   } mem_wr_type;

   typedef struct packed {
      logic                 show;
      logic [FillWidth-1:0] trail;
      logic [SkipWidth-1:0] skip;
   } track_type;

   function automatic logic [FillWidth-1:0] eff_ctx(input logic [CtxWidth-1:0] c);
      logic [FillWidth-1:0] r;
      if (CmpWidth'(c) >= CmpWidth'(MaxContext)) begin
         r = FillWidth'(MaxContext);
      end else begin
         r = FillWidth'(c);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/cwls_delay_mem.sv =====
// ----------------------------------------------------------------------------
// cwls_delay_mem
// Delay FIFO storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cwls_delay_mem (
   input  logic                           clock,
   input  cwls_pkg::mem_wr_type           wr,
   input  logic [cwls_pkg::HeadWidth-1:0] rd_addr,
   output logic [cwls_pkg::TagWidth-1:0]  rd_tag,
   output logic                           rd_mark
);

   logic [cwls_pkg::TagWidth:0] mem_ff [cwls_pkg::MaxContext];
   logic [cwls_pkg::TagWidth:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= {wr.mark, wr.tag};
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_tag  = rd_data_ff[cwls_pkg::TagWidth-1:0];
   assign rd_mark = rd_data_ff[cwls_pkg::TagWidth];

endmodule

// ===== rtl/core/cwls_step_unit.sv =====
// ----------------------------------------------------------------------------
// cwls_step_unit
// Show/skip decision and trail tracking for one entry leaving the delay stage.
// ----------------------------------------------------------------------------
module cwls_step_unit (
   input  cwls_pkg::track_type            cur,
   input  logic                           mark,
   input  logic [cwls_pkg::FillWidth-1:0] eff,
   output cwls_pkg::track_type            nxt,
   output logic                           emit
);

   logic [cwls_pkg::FillWidth-1:0] trail_up;

   always_comb begin
      emit     = cur.show;
      nxt      = cur;
      trail_up = cur.trail;
      if (cur.show) begin
         nxt.skip = '0;
      end else if (cur.skip != cwls_pkg::SkipMax) begin
         nxt.skip = cur.skip + 1'b1;
      end
      if (eff != '0) begin
         if (mark) begin
            nxt.trail = '0;
         end else begin
            if (cur.trail < eff) begin
               trail_up = cur.trail + 1'b1;
            end
            nxt.trail = trail_up;
            if (trail_up == eff) begin
               nxt.show = 1'b0;
            end
         end
      end
   end

endmodule

// ===== rtl/core/cwls_seq.sv =====
// ----------------------------------------------------------------------------
// cwls_seq
// Sequencer: evaluates one word, pushes/pops the delay FIFO, drains it at
// end of stream and hands results to the output stage.
// ----------------------------------------------------------------------------
module cwls_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [cwls_pkg::CtxWidth-1:0]  csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [cwls_pkg::TagWidth-1:0]  req_tag,
   input  logic                           req_marked,
   output logic                           res_valid,
   input  logic                           res_ready,
   output cwls_pkg::result_type           res,
   output cwls_pkg::mem_wr_type           mem_wr,
   output logic [cwls_pkg::HeadWidth-1:0] mem_rd_addr,
   input  logic [cwls_pkg::TagWidth-1:0]  mem_rd_tag,
   input  logic                           mem_rd_mark
);

   localparam int FW = cwls_pkg::FillWidth;
   localparam int HW = cwls_pkg::HeadWidth;

   cwls_pkg::seq_state_type state_ff, state_in;

   logic [cwls_pkg::CtxWidth-1:0]  ctx_ff, ctx_in;
   logic [HW-1:0]                  head_ff, head_in;
   logic [FW-1:0]                  fill_ff, fill_in;
   cwls_pkg::track_type            trk_ff, trk_in;
   logic                           mode_ff, mode_in;
   logic [cwls_pkg::TagWidth-1:0]  tag_ff, tag_in;
   logic                           mark_ff, mark_in;
   logic [cwls_pkg::SkipWidth-1:0] sep_cnt_ff, sep_cnt_in;
   logic [cwls_pkg::TagWidth-1:0]  ent_tag_ff, ent_tag_in;
   logic                           ent_mark_ff, ent_mark_in;
   logic                           emit_ent_ff, emit_ent_in;

   logic [FW-1:0]                  eff;
   logic                           ctx_zero;
   logic [FW-1:0]                  head_up;
   logic [HW-1:0]                  head_wrap;
   logic [FW:0]                    pos_sum;
   logic [HW-1:0]                  push_pos;

   cwls_pkg::track_type            ev_trk;
   logic                           ev_sep;
   logic                           ev_pass;
   logic                           ev_full;
   logic [cwls_pkg::TagWidth-1:0]  ev_tag;
   logic                           ev_mark;
   logic                           ev_ent;

   cwls_pkg::track_type            unit_cur, unit_nxt;
   logic                           unit_mark, unit_emit;
   logic                           drain_go;

   assign eff       = cwls_pkg::eff_ctx(ctx_ff);
   assign ctx_zero  = (eff == '0);
   assign head_up   = FW'(head_ff) + 1'b1;
   assign head_wrap = (head_up >= eff) ? '0 : HW'(head_up);
   assign pos_sum   = (FW + 1)'(head_ff) + (FW + 1)'(fill_ff);
   assign push_pos  = (pos_sum >= (FW + 1)'(eff)) ? HW'(pos_sum - (FW + 1)'(eff))
                                                  : HW'(pos_sum);

   // entry evaluation ahead of the shared step unit
   always_comb begin
      ev_trk = trk_ff;
      ev_sep = mark_ff && !trk_ff.show && (trk_ff.skip != '0);
      if (mark_ff) begin
         ev_trk.show  = 1'b1;
         ev_trk.trail = '0;
      end else if (ctx_zero) begin
         ev_trk.show = 1'b0;
      end
      if (ev_sep) begin
         ev_trk.skip = '0;
      end
      ev_full = (fill_ff >= eff);
      if (ctx_zero) begin
         ev_pass = 1'b1;
         ev_tag  = tag_ff;
         ev_mark = mark_ff;
      end else if (!ev_full) begin
         ev_pass = 1'b0;
         ev_tag  = tag_ff;
         ev_mark = mark_ff;
      end else begin
         ev_pass = 1'b1;
         ev_tag  = mem_rd_tag;
         ev_mark = mem_rd_mark;
      end
   end

   always_comb begin
      if (state_ff == cwls_pkg::ST_DRAIN) begin
         unit_cur  = trk_ff;
         unit_mark = mem_rd_mark;
      end else begin
         unit_cur  = ev_trk;
         unit_mark = ev_mark;
      end
   end

   cwls_step_unit u_step (
      .cur  (unit_cur),
      .mark (unit_mark),
      .eff  (eff),
      .nxt  (unit_nxt),
      .emit (unit_emit)
   );

   assign ev_ent   = ev_pass && unit_emit;
   assign drain_go = !unit_emit || res_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cwls_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cwls_pkg::ST_EVAL;
            end
         end
         cwls_pkg::ST_EVAL: begin
            if (mode_ff == cwls_pkg::ModeDrain) begin
               state_in = (fill_ff != '0) ? cwls_pkg::ST_DRAIN : cwls_pkg::ST_FIN;
            end else if (ev_sep) begin
               state_in = cwls_pkg::ST_SEP;
            end else if (ev_ent) begin
               state_in = cwls_pkg::ST_ENT;
            end else begin
               state_in = cwls_pkg::ST_IDLE;
            end
         end
         cwls_pkg::ST_SEP: begin
            if (res_ready) begin
               state_in = emit_ent_ff ? cwls_pkg::ST_ENT : cwls_pkg::ST_IDLE;
            end
         end
         cwls_pkg::ST_ENT: begin
            if (res_ready) begin
               state_in = cwls_pkg::ST_IDLE;
            end
         end
         cwls_pkg::ST_DRAIN: begin
            if (drain_go && (fill_ff == FW'(1))) begin
               state_in = cwls_pkg::ST_FIN;
            end
         end
         cwls_pkg::ST_FIN: begin
            if ((trk_ff.skip == '0) || res_ready) begin
               state_in = cwls_pkg::ST_IDLE;
            end
         end
         default: state_in = cwls_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ctx_in      = ctx_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      trk_in      = trk_ff;
      mode_in     = mode_ff;
      tag_in      = tag_ff;
      mark_in     = mark_ff;
      sep_cnt_in  = sep_cnt_ff;
      ent_tag_in  = ent_tag_ff;
      ent_mark_in = ent_mark_ff;
      emit_ent_in = emit_ent_ff;
      mem_wr      = '0;
      res_valid   = 1'b0;
      res         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         cwls_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in = req_mode;
               tag_in  = req_tag;
               mark_in = req_marked;
            end
         end
         cwls_pkg::ST_EVAL: begin
            if (mode_ff == cwls_pkg::ModeEntry) begin
               sep_cnt_in  = trk_ff.skip;
               ent_tag_in  = ev_tag;
               ent_mark_in = ev_mark;
               emit_ent_in = ev_ent;
               trk_in      = ev_pass ? unit_nxt : ev_trk;
               if (!ctx_zero) begin
                  mem_wr.en   = 1'b1;
                  mem_wr.tag  = tag_ff;
                  mem_wr.mark = mark_ff;
                  if (!ev_full) begin
                     mem_wr.addr = push_pos;
                     fill_in     = fill_ff + 1'b1;
                  end else begin
                     mem_wr.addr = head_ff;
                     head_in     = head_wrap;
                  end
               end
            end
         end
         cwls_pkg::ST_SEP: begin
            res_valid   = 1'b1;
            res.kind    = cwls_pkg::KindSep;
            res.skipped = sep_cnt_ff;
            res.last    = !emit_ent_ff;
         end
         cwls_pkg::ST_ENT: begin
            res_valid  = 1'b1;
            res.kind   = cwls_pkg::KindEntry;
            res.tag    = ent_tag_ff;
            res.marked = ent_mark_ff;
            res.last   = 1'b1;
         end
         cwls_pkg::ST_DRAIN: begin
            res_valid  = unit_emit;
            res.kind   = cwls_pkg::KindEntry;
            res.tag    = mem_rd_tag;
            res.marked = mem_rd_mark;
            res.last   = (fill_ff == FW'(1));
            if (drain_go) begin
               trk_in  = unit_nxt;
               head_in = head_wrap;
               fill_in = fill_ff - 1'b1;
            end
         end
         cwls_pkg::ST_FIN: begin
            res_valid   = (trk_ff.skip != '0);
            res.kind    = cwls_pkg::KindSep;
            res.skipped = trk_ff.skip;
            res.last    = 1'b1;
            if ((trk_ff.skip == '0) || res_ready) begin
               trk_in  = '0;
               head_in = '0;
               fill_in = '0;
            end
         end
         default: begin
         end
      endcase
      if (csr_write_en) begin
         ctx_in  = csr_write_data;
         head_in = '0;
         fill_in = '0;
      end
   end

   // read the FIFO slot that will be at the head next cycle
   assign mem_rd_addr = head_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwls_pkg::ST_IDLE;
         ctx_ff   <= '0;
         head_ff  <= '0;
         fill_ff  <= '0;
         trk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         trk_ff   <= trk_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      tag_ff      <= tag_in;
      mark_ff     <= mark_in;
      sep_cnt_ff  <= sep_cnt_in;
      ent_tag_ff  <= ent_tag_in;
      ent_mark_ff <= ent_mark_in;
      emit_ent_ff <= emit_ent_in;
   end

endmodule

// ===== rtl/core/context_window_line_selector_top.sv =====
// ----------------------------------------------------------------------------
// context_window_line_selector_top
// Shows matched log entries with surrounding context, emits separators
// carrying skip counts, and drains the delay FIFO at end of stream.
//
//   channel   ports      direction   word
//   req       req_*      in          mode, entry tag, entry marked
//   rsp       rsp_*      out         kind, tag, marked, skip count, last
//   csr       csr_*      in          context_lines, no wait, no read-back
//
// An entry word passes the accept and evaluate steps of the sequencer,
// then one result step per result (up to 2): separator, entry or both.
// An end-of-stream word pops one entry per cycle, unless a shown entry
// stalls, via the registered read port, then the closing separator step.
// Synchronous reset clears control state; FIFO contents are not cleared.
// A low rsp_ready holds the sequencer at the pending result.
// ----------------------------------------------------------------------------
module context_window_line_selector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [cwls_pkg::CtxWidth-1:0]       csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [cwls_pkg::TagWidth-1:0]       req_entry_tag,
   input  logic                                req_entry_marked,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [cwls_pkg::TagWidth-1:0]       rsp_shown_tag,
   output logic                                rsp_shown_marked,
   output logic [cwls_pkg::SkipWidth-1:0]      rsp_skipped_count,
   output logic                                rsp_last
);

   cwls_pkg::result_type            res;
   logic                            res_valid;
   logic                            res_ready;
   cwls_pkg::mem_wr_type            mem_wr;
   logic [cwls_pkg::HeadWidth-1:0]  mem_rd_addr;
   logic [cwls_pkg::TagWidth-1:0]   mem_rd_tag;
   logic                            mem_rd_mark;

   cwls_pkg::result_type            rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   cwls_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_tag        (req_entry_tag),
      .req_marked     (req_entry_marked),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res),
      .mem_wr         (mem_wr),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_tag     (mem_rd_tag),
      .mem_rd_mark    (mem_rd_mark)
   );

   cwls_delay_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_tag  (mem_rd_tag),
      .rd_mark (mem_rd_mark)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_shown_tag     = rsp_ff.tag;
   assign rsp_shown_marked  = rsp_ff.marked;
   assign rsp_skipped_count = rsp_ff.skipped;
   assign rsp_last          = rsp_ff.last;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for context_window_line_selector_top. A directed
// table walks the context edge cases (no context, context above the limit,
// register writes that drop buffered entries, drains with and without
// skips), then random phases sweep context settings and flow control. Every
// output word is checked against a local predictor or a hand-typed outcome.
// ----------------------------------------------------------------------------
module tb_top;
   import cwls_pkg::*;

   localparam int SettleCycles = 40;
   localparam int CycleLimit   = 600000;

   typedef enum logic {SK_WORD, SK_CSR} step_kind_type;

   typedef struct {
      step_kind_type       kind;
      logic                mode;
      logic [TagWidth-1:0] tag;
      logic                marked;
      int                  typed_n;
      result_type          typed;
   } step_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 csr_write_en      = 1'b0;
   logic [CtxWidth-1:0]  csr_write_data    = '0;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic                 req_mode          = ModeEntry;
   logic [TagWidth-1:0]  req_entry_tag     = '0;
   logic                 req_entry_marked  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic                 rsp_kind;
   logic [TagWidth-1:0]  rsp_shown_tag;
   logic                 rsp_shown_marked;
   logic [SkipWidth-1:0] rsp_skipped_count;
   logic                 rsp_last;

   int sender_gap_pct = 0;
   int rsp_stall_pct  = 0;
   int errors         = 0;
   int words_sent     = 0;
   int lines_seen     = 0;
   int settings_seen  = 0;
   int cycles         = 0;

   // predictor state
   logic [CtxWidth-1:0]  ctx_reg = '0;
   logic [TagWidth-1:0]  fifo_tag [MaxContext];
   logic                 fifo_mark [MaxContext];
   int unsigned          fifo_fill = 0;
   int unsigned          fifo_head = 0;
   logic                 showing = 1'b0;
   int unsigned          trail = 0;
   logic [SkipWidth-1:0] skip_run = '0;
   result_type           batch[$];
   result_type           lines_due[$];

   context_window_line_selector_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_entry_tag     (req_entry_tag),
      .req_entry_marked  (req_entry_marked),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_shown_tag     (rsp_shown_tag),
      .rsp_shown_marked  (rsp_shown_marked),
      .rsp_skipped_count (rsp_skipped_count),
      .rsp_last          (rsp_last)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("FAIL context_window_line_selector_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic result_type mk_line(logic kind, logic [TagWidth-1:0] tag, logic mark,
                                          logic [SkipWidth-1:0] skipped);
      result_type r;
      r.kind    = kind;
      r.tag     = tag;
      r.marked  = mark;
      r.skipped = skipped;
      r.last    = 1'b0;
      return r;
   endfunction

   function automatic int unsigned window();
      return (int'(ctx_reg) > MaxContext) ? MaxContext : int'(ctx_reg);
   endfunction

   // an entry leaving the delay stage: shown or counted, then trail update
   function automatic void show_or_count(logic [TagWidth-1:0] tag, logic mark);
      int unsigned w;
      w = window();
      if (showing) begin
         batch.push_back(mk_line(KindEntry, tag, mark, '0));
         skip_run = '0;
      end else if (skip_run != SkipMax) begin
         skip_run = skip_run + 1'b1;
      end
      if (w != 0) begin
         if (mark) begin
            trail = 0;
         end else begin
            if (trail < w) trail++;
            if (trail == w) showing = 1'b0;
         end
      end
   endfunction

   function automatic void select_lines(logic mode, logic [TagWidth-1:0] tag, logic mark);
      int unsigned         w;
      int unsigned         pos;
      logic                pass;
      logic [TagWidth-1:0] out_tag;
      logic                out_mark;
      w = window();
      batch.delete();
      if (mode == ModeDrain) begin
         while (fifo_fill > 0) begin
            out_tag  = fifo_tag[fifo_head];
            out_mark = fifo_mark[fifo_head];
            fifo_head++;
            if (fifo_head >= w) fifo_head = 0;
            fifo_fill--;
            show_or_count(out_tag, out_mark);
         end
         if (skip_run != 0) batch.push_back(mk_line(KindSep, '0, 1'b0, skip_run));
         fifo_fill = 0;
         fifo_head = 0;
         showing   = 1'b0;
         trail     = 0;
         skip_run  = '0;
      end else begin
         pass     = 1'b1;
         out_tag  = tag;
         out_mark = mark;
         if (mark) begin
            if (!showing && skip_run != 0) begin
               batch.push_back(mk_line(KindSep, '0, 1'b0, skip_run));
               skip_run = '0;
            end
            showing = 1'b1;
            trail   = 0;
         end else if (w == 0) begin
            showing = 1'b0;
         end
         if (w != 0) begin
            if (fifo_fill < w) begin
               pos = fifo_head + fifo_fill;
               if (pos >= w) pos -= w;
               fifo_tag[pos]  = tag;
               fifo_mark[pos] = mark;
               fifo_fill++;
               pass = 1'b0;
            end else begin
               out_tag              = fifo_tag[fifo_head];
               out_mark             = fifo_mark[fifo_head];
               fifo_tag[fifo_head]  = tag;
               fifo_mark[fifo_head] = mark;
               fifo_head++;
               if (fifo_head >= w) fifo_head = 0;
            end
         end
         if (pass) show_or_count(out_tag, out_mark);
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [SkipWidth-1:0] exp_v,
                                       logic [SkipWidth-1:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type exp_line;
      if (!reset && rsp_valid && rsp_ready) begin
         lines_seen++;
         if (lines_due.size() == 0) begin
            $display("%0t: unexpected word: expected none, got kind %0h tag %0h skip %0h",
                     $time, rsp_kind, rsp_shown_tag, rsp_skipped_count);
            errors++;
         end else begin
            exp_line = lines_due.pop_front();
            check_field("kind", SkipWidth'(exp_line.kind), SkipWidth'(rsp_kind));
            check_field("shown_tag", SkipWidth'(exp_line.tag), SkipWidth'(rsp_shown_tag));
            check_field("shown_marked", SkipWidth'(exp_line.marked),
                        SkipWidth'(rsp_shown_marked));
            check_field("skipped_count", exp_line.skipped, rsp_skipped_count);
            check_field("last", SkipWidth'(exp_line.last), SkipWidth'(rsp_last));
         end
      end
   end

   function automatic step_type step_word(logic mode, logic [TagWidth-1:0] tag, logic marked);
      step_type s;
      s.kind    = SK_WORD;
      s.mode    = mode;
      s.tag     = tag;
      s.marked  = marked;
      s.typed_n = -1;
      s.typed   = '0;
      return s;
   endfunction

   // typed_n of 0 or 1: the whole outcome of the word is given by hand
   function automatic step_type step_typed(logic mode, logic [TagWidth-1:0] tag, logic marked,
                                           int typed_n, logic kind,
                                           logic [TagWidth-1:0] exp_tag, logic exp_mark,
                                           logic [SkipWidth-1:0] exp_skip);
      step_type s;
      s         = step_word(mode, tag, marked);
      s.typed_n = typed_n;
      s.typed   = mk_line(kind, exp_tag, exp_mark, exp_skip);
      return s;
   endfunction

   function automatic step_type step_csr(logic [CtxWidth-1:0] value);
      step_type s;
      s     = step_word(ModeEntry, TagWidth'(value), 1'b0);
      s.kind = SK_CSR;
      return s;
   endfunction

   task automatic set_idling(int phase_mode);
      case (phase_mode)
         1: begin
            sender_gap_pct = 67;
            rsp_stall_pct  = 0;
         end
         2: begin
            sender_gap_pct = 0;
            rsp_stall_pct  = 67;
         end
         3: begin
            sender_gap_pct = 6;
            rsp_stall_pct  = 6;
         end
         default: begin
            sender_gap_pct = 0;
            rsp_stall_pct  = 0;
         end
      endcase
   endtask

   task automatic send_word(step_type s);
      while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= s.mode;
      req_entry_tag    <= s.tag;
      req_entry_marked <= s.marked;
      do @(posedge clock); while (!req_ready);
      select_lines(s.mode, s.tag, s.marked);
      if (s.typed_n >= 0) begin
         batch.delete();
         if (s.typed_n == 1) begin
            s.typed.last = 1'b1;
            batch.push_back(s.typed);
         end
      end
      foreach (batch[i]) lines_due.push_back(batch[i]);
      words_sent++;
   endtask

   task automatic write_context(logic [CtxWidth-1:0] value);
      req_valid <= 1'b0;
      while (lines_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      ctx_reg   = value;
      fifo_fill = 0;
      fifo_head = 0;
      settings_seen++;
   endtask

   initial begin
      step_type            script[$];
      step_type            s;
      logic [CtxWidth-1:0] ctx_plan[10];
      int                  mark_pct;
      int                  n_items;

      ctx_plan = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd2, 5'd9, 5'd16, 5'd3, 5'd17};

      // no context after reset
      script.push_back(step_typed(ModeDrain, 16'hFFFF, 1'b1, 0, KindEntry, '0, 1'b0, '0));
      script.push_back(step_typed(ModeEntry, 16'hFFFF, 1'b1, 1, KindEntry, 16'hFFFF, 1'b1,
                                  '0));
      script.push_back(step_typed(ModeEntry, 16'h0000, 1'b0, 0, KindEntry, '0, 1'b0, '0));
      script.push_back(step_typed(ModeEntry, 16'h5A5A, 1'b0, 0, KindEntry, '0, 1'b0, '0));
      script.push_back(step_word(ModeEntry, 16'h0001, 1'b1));
      script.push_back(step_typed(ModeEntry, 16'h8000, 1'b0, 0, KindEntry, '0, 1'b0, '0));
      script.push_back(step_typed(ModeDrain, 16'h0000, 1'b0, 1, KindSep, '0, 1'b0, 24'd1));
      // three entries of context, match in the middle, drain with buffered entries
      script.push_back(step_csr(5'd3));
      script.push_back(step_word(ModeEntry, 16'h0010, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h0011, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h0012, 1'b1));
      script.push_back(step_word(ModeEntry, 16'h0013, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h0014, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h0015, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h0016, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h0017, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h0018, 1'b0));
      script.push_back(step_word(ModeDrain, 16'h0000, 1'b0));
      // context above the limit, then a write that drops buffered entries
      script.push_back(step_csr(5'd31));
      script.push_back(step_word(ModeEntry, 16'h00A0, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h00A1, 1'b1));
      script.push_back(step_word(ModeEntry, 16'h00A2, 1'b0));
      script.push_back(step_csr(5'd2));
      script.push_back(step_word(ModeEntry, 16'h00B0, 1'b1));
      script.push_back(step_word(ModeEntry, 16'h00B1, 1'b0));
      script.push_back(step_word(ModeEntry, 16'h00B2, 1'b0));
      script.push_back(step_word(ModeDrain, 16'h0000, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == SK_CSR) begin
            write_context(CtxWidth'(script[i].tag));
         end else begin
            send_word(script[i]);
         end
      end

      for (int p = 0; p < 10; p++) begin
         write_context(ctx_plan[p]);
         set_idling(p % 4);
         mark_pct = $urandom_range(40, 5);
         n_items  = $urandom_range(10, 5);
         for (int k = 0; k < n_items; k++) begin
            if (k == n_items - 1 || $urandom_range(99) < 6) begin
               s = step_word(ModeDrain, TagWidth'($urandom_range(65535)),
                             1'($urandom_range(1)));
            end else begin
               s = step_word(ModeEntry, TagWidth'($urandom_range(65535)),
                             $urandom_range(99) < mark_pct);
            end
            send_word(s);
         end
      end

      req_valid <= 1'b0;
      while (lines_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("sent %0d words over %0d context settings, checked %0d output words",
               words_sent, settings_seen, lines_seen);
      $display("flow control: free running, sender gaps, receiver stalls, light mix");
      if (errors == 0) begin
         $display("PASS context_window_line_selector_top");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL context_window_line_selector_top");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cwls_pkg.sv
rtl/core/cwls_delay_mem.sv
rtl/core/cwls_step_unit.sv
rtl/core/cwls_seq.sv
rtl/core/context_window_line_selector_top.sv
dv/tb_top.sv
